// ===== rtl/pbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfe_pkg
// Shared constants, codes and types of the palette blend/fade engine.
// ----------------------------------------------------------------------------
package pbfe_pkg;

    // Palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(PAL_ENTRIES);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int RGB_W       = 24;
    localparam int CH_W        = 8;

    // Interpolation
    localparam logic [6:0]  PCT_FULL  = 7'd100;
    localparam int          NUM_W     = 16;
    localparam int          PROD_W    = CH_W + NUM_W;

    // Action codes
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_FILL  = 3'd2;
    localparam logic [2:0] ACT_BLEND = 3'd3;
    localparam logic [2:0] ACT_SNAP  = 3'd4;
    localparam logic [2:0] ACT_FADE  = 3'd5;

    // Status of the interpolation unit
    typedef struct packed {
        logic busy;
        logic done;
    } lerp_stat_t;

endpackage

// ===== rtl/pbfe_ram.sv =====
// ----------------------------------------------------------------------------
// pbfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/pbfe_lerp_unit.sv =====
// ----------------------------------------------------------------------------
// pbfe_lerp_unit
// One channel: cur + (tgt - cur) * num / den, truncated toward zero.
// A multiply step, then eight restoring divide steps (quotient < 256).
// ----------------------------------------------------------------------------
module pbfe_lerp_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pbfe_pkg::CH_W-1:0]     cur,
    input  logic [pbfe_pkg::CH_W-1:0]     tgt,
    input  logic [pbfe_pkg::NUM_W-1:0]    num,
    input  logic [pbfe_pkg::NUM_W-1:0]    den,
    output pbfe_pkg::lerp_stat_t          stat,
    output logic [pbfe_pkg::CH_W-1:0]     result
);
    import pbfe_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } lerp_state_t;

    lerp_state_t          state_reg, state_next;
    logic                 neg_reg, neg_next;
    logic [CH_W-1:0]      mag_reg, mag_next;
    logic [CH_W-1:0]      cur_reg, cur_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NUM_W-1:0]     den_reg, den_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [CH_W-1:0]      q_reg, q_next;
    logic [2:0]           step_reg, step_next;
    logic                 done_reg, done_next;
    logic [CH_W-1:0]      result_reg, result_next;
    logic [PROD_W-1:0]    dsh;

    assign dsh = PROD_W'(den_reg) << step_reg;

    // sequencer and datapath
    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        cur_next    = cur_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    neg_next   = (tgt < cur);
                    mag_next   = (tgt < cur) ? (cur - tgt) : (tgt - cur);
                    cur_next   = cur;
                    num_next   = num;
                    den_next   = den;
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                rem_next   = PROD_W'(mag_reg) * PROD_W'(num_reg);
                q_next     = '0;
                step_next  = 3'd7;
                state_next = L_DIV;
            end
            L_DIV:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_next         = rem_reg - dsh;
                    q_next[step_reg] = 1'b1;
                end
                if (step_reg == 3'd0)
                begin
                    result_next = neg_reg ? (cur_reg - q_next) : (cur_reg + q_next);
                    done_next   = 1'b1;
                    state_next  = L_IDLE;
                end
                else
                begin
                    step_next = step_reg - 3'd1;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        cur_reg    <= cur_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    assign stat.busy = (state_reg != L_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/palette_blend_fade_engine_core.sv =====
// ----------------------------------------------------------------------------
// palette_blend_fade_engine_core
// 256-entry RGB palette with snapshot store; write, read, fill, blend,
// snapshot and fade-step commands, one result item per command.
// ----------------------------------------------------------------------------
// Commands run one at a time; in_ready is low while a command is in work.
// Fill does one palette write per cycle. Snapshot does one palette read per
// cycle, written to the snapshot in the following cycle. Blend and fade step
// work entry by entry: the channels go one after another through a single
// interpolation unit of a multiply step and eight divide steps, plus fetch
// and write-back. A fade step with zero duration writes the target without
// interpolation. The result item waits in an output register.
// ----------------------------------------------------------------------------
module palette_blend_fade_engine_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                action,
    input  logic [7:0]                start_index,
    input  logic [8:0]                entry_count,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic [6:0]                percent,
    input  logic [15:0]               elapsed_ms,
    input  logic [15:0]               duration_ms,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_red,
    output logic [7:0]                out_green,
    output logic [7:0]                out_blue,
    output logic                      status
);
    import pbfe_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_WRITE   = 12'b000000000010,
        S_FILL    = 12'b000000000100,
        S_FETCH   = 12'b000000001000,
        S_WAIT    = 12'b000000010000,
        S_CH      = 12'b000000100000,
        S_CHW     = 12'b000001000000,
        S_WB      = 12'b000010000000,
        S_SNAP    = 12'b000100000000,
        S_SNAPEND = 12'b001000000000,
        S_RDRES   = 12'b010000000000,
        S_RDWAIT  = 12'b100000000000
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [2:0]          act_reg, act_next;
    logic [ADDR_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic [RGB_W-1:0]    tgt_reg, tgt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [NUM_W-1:0]    den_reg, den_next;
    logic                stat_reg, stat_next;
    logic [RGB_W-1:0]    ent_reg, ent_next;
    logic [RGB_W-1:0]    new_reg, new_next;
    logic [1:0]          ch_reg, ch_next;
    logic                cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]   cp_addr_reg, cp_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [RGB_W-1:0]    out_rgb_reg, out_rgb_next;
    logic                out_stat_reg, out_stat_next;

    logic                in_acc;
    logic [IDX_W:0]      range_end;
    logic [6:0]          pct_sat;
    logic [15:0]         el_sat;

    logic                pal_we, pal_re, snp_re;
    logic [ADDR_W-1:0]   pal_waddr, pal_raddr;
    logic [RGB_W-1:0]    pal_wdata, pal_rdata, snp_rdata;

    logic                lerp_start;
    logic [CH_W-1:0]     lerp_cur, lerp_tgt, lerp_res;
    lerp_stat_t          lerp_stat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign range_end = (IDX_W + 1)'(start_index) + (IDX_W + 1)'(entry_count);
    assign pct_sat   = (percent > PCT_FULL) ? PCT_FULL : percent;
    assign el_sat    = (elapsed_ms > duration_ms) ? duration_ms : elapsed_ms;

    // channel select for the interpolation unit
    always_comb
    begin
        case (ch_reg)
            2'd0:    begin lerp_cur = ent_reg[7:0];   lerp_tgt = tgt_reg[7:0];   end
            2'd1:    begin lerp_cur = ent_reg[15:8];  lerp_tgt = tgt_reg[15:8];  end
            default: begin lerp_cur = ent_reg[23:16]; lerp_tgt = tgt_reg[23:16]; end
        endcase
    end

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        tgt_next       = tgt_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        stat_next      = stat_reg;
        ent_next       = ent_reg;
        new_next       = new_reg;
        ch_next        = ch_reg;
        cp_valid_next  = 1'b0;
        cp_addr_next   = cp_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rgb_next   = out_rgb_reg;
        out_stat_next  = out_stat_reg;
        pal_we         = 1'b0;
        pal_waddr      = idx_reg[ADDR_W-1:0];
        pal_wdata      = tgt_reg;
        pal_re         = 1'b0;
        pal_raddr      = idx_reg[ADDR_W-1:0];
        snp_re         = 1'b0;
        lerp_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    act_next   = action;
                    start_next = start_index;
                    idx_next   = IDX_W'(start_index);
                    tgt_next   = {blue, green, red};
                    stat_next  = 1'b0;
                    end_next   = IDX_W'(start_index);
                    if (action == ACT_FILL || action == ACT_BLEND || action == ACT_FADE)
                    begin
                        if (range_end > (IDX_W + 1)'(PAL_ENTRIES))
                        begin
                            end_next  = IDX_W'(PAL_ENTRIES);
                            stat_next = 1'b1;
                        end
                        else
                        begin
                            end_next = range_end[IDX_W-1:0];
                        end
                    end
                    if (action == ACT_BLEND)
                    begin
                        num_next = NUM_W'(pct_sat);
                        den_next = NUM_W'(PCT_FULL);
                    end
                    else
                    begin
                        num_next = el_sat;
                        den_next = duration_ms;
                    end
                    unique case (action)
                        ACT_WRITE:            state_next = S_WRITE;
                        ACT_FILL:             state_next = S_FILL;
                        ACT_BLEND, ACT_FADE:  state_next = S_FETCH;
                        ACT_SNAP:
                        begin
                            idx_next   = '0;
                            state_next = S_SNAP;
                        end
                        default:              state_next = S_RDRES;
                    endcase
                end
            end
            S_WRITE:
            begin
                pal_we     = 1'b1;
                state_next = S_RDRES;
            end
            S_FILL:
            begin
                if (idx_reg == end_reg)
                begin
                    state_next = S_RDRES;
                end
                else
                begin
                    pal_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                if (idx_reg == end_reg)
                begin
                    state_next = S_RDRES;
                end
                else
                begin
                    pal_re     = (act_reg == ACT_BLEND);
                    snp_re     = (act_reg == ACT_FADE);
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                ent_next = (act_reg == ACT_BLEND) ? pal_rdata : snp_rdata;
                ch_next  = 2'd0;
                if (act_reg == ACT_FADE && den_reg == '0)
                begin
                    new_next   = tgt_reg;
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_CH;
                end
            end
            S_CH:
            begin
                lerp_start = 1'b1;
                state_next = S_CHW;
            end
            S_CHW:
            begin
                if (lerp_stat.done)
                begin
                    case (ch_reg)
                        2'd0:    new_next[7:0]   = lerp_res;
                        2'd1:    new_next[15:8]  = lerp_res;
                        default: new_next[23:16] = lerp_res;
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        state_next = S_WB;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_CH;
                    end
                end
            end
            S_WB:
            begin
                pal_we     = 1'b1;
                pal_wdata  = new_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_FETCH;
            end
            S_SNAP:
            begin
                pal_re        = 1'b1;
                cp_valid_next = 1'b1;
                cp_addr_next  = idx_reg[ADDR_W-1:0];
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(PAL_ENTRIES - 1))
                begin
                    state_next = S_SNAPEND;
                end
            end
            S_SNAPEND:
            begin
                state_next = S_RDRES;
            end
            S_RDRES:
            begin
                pal_re     = 1'b1;
                pal_raddr  = start_reg;
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rgb_next   = pal_rdata;
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cp_valid_reg  <= cp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        start_reg    <= start_next;
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        tgt_reg      <= tgt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        stat_reg     <= stat_next;
        ent_reg      <= ent_next;
        new_reg      <= new_next;
        ch_reg       <= ch_next;
        cp_addr_reg  <= cp_addr_next;
        out_rgb_reg  <= out_rgb_next;
        out_stat_reg <= out_stat_next;
    end

    // palette store
    pbfe_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pal_waddr),
        .wr_data (pal_wdata),
        .rd_en   (pal_re),
        .rd_addr (pal_raddr),
        .rd_data (pal_rdata)
    );

    // snapshot store, written from the palette read data in the following cycle
    pbfe_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PAL_ENTRIES)
    ) u_snapshot (
        .clk     (clk),
        .wr_en   (cp_valid_reg),
        .wr_addr (cp_addr_reg),
        .wr_data (pal_rdata),
        .rd_en   (snp_re),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (snp_rdata)
    );

    // shared interpolation unit
    pbfe_lerp_unit u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .cur    (lerp_cur),
        .tgt    (lerp_tgt),
        .num    (num_reg),
        .den    (den_reg),
        .stat   (lerp_stat),
        .result (lerp_res)
    );

    assign out_valid = out_valid_reg;
    assign out_red   = out_rgb_reg[7:0];
    assign out_green = out_rgb_reg[15:8];
    assign out_blue  = out_rgb_reg[23:16];
    assign status    = out_stat_reg;

    // no new command while the interpolation unit still works
    a_ready_lerp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !lerp_stat.busy)
        else $error("command accepted while interpolation unit busy");

    // snapshot copies only during the snapshot sweep
    a_copy_window: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> (state_reg == S_SNAP || state_reg == S_SNAPEND))
        else $error("snapshot write outside snapshot sweep");

    // range walk never passes the clipped end
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL || state_reg == S_FETCH) |-> idx_reg <= end_reg)
        else $error("range index beyond end");

    // a lerp result only arrives while the sequencer waits for it
    a_lerp_done: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_stat.done |-> state_reg == S_CHW)
        else $error("interpolation result without waiting sequencer");

endmodule

// ===== dv/tb_palette_blend_fade_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_palette_blend_fade_engine_core
// Self-checking bench: a directed opener, then random commands, run through
// four phases of sender/receiver idling. Each result item is checked against
// a local model of the palette and snapshot stores.
// ----------------------------------------------------------------------------
module tb_palette_blend_fade_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pbfe_pkg::*;

    localparam int N_RANDOM    = 400;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [2:0]  action;
        logic [7:0]  start_index;
        logic [8:0]  entry_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [6:0]  percent;
        logic [15:0] elapsed_ms;
        logic [15:0] duration_ms;
    } palette_cmd_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       st;
    } entry_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0]  action = '0;
    logic [7:0]  start_index = '0;
    logic [8:0]  entry_count = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [6:0]  percent = '0;
    logic [15:0] elapsed_ms = '0;
    logic [15:0] duration_ms = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       status;

    palette_cmd_t  cmd_queue[$];
    entry_result_t result_queue[$];
    logic [23:0]   pal_model[PAL_ENTRIES];
    logic [23:0]   snap_model[PAL_ENTRIES];
    int total_cmds;
    int sent_cmds = 0;
    int mismatches = 0;
    int cycles = 0;
    bit in_taken = 1'b0;
    bit stim_done = 1'b0;

    palette_blend_fade_engine_core i_dut (.*);

    // clock and run limit
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one channel: (tgt - cur) * num / den + cur, truncating toward zero
    function automatic logic [7:0] lerp_ch(logic [7:0] cur, logic [7:0] tgt, int num, int den);
        int diff;
        int v;
        diff = int'(tgt) - int'(cur);
        v = (diff * num) / den + int'(cur);
        return v[7:0];
    endfunction

    function automatic logic [23:0] lerp_rgb(logic [23:0] cur, logic [23:0] tgt, int num, int den);
        return {lerp_ch(cur[23:16], tgt[23:16], num, den),
                lerp_ch(cur[15:8], tgt[15:8], num, den),
                lerp_ch(cur[7:0], tgt[7:0], num, den)};
    endfunction

    // apply one command to the local stores and queue its result
    task automatic predict_palette(palette_cmd_t c);
        int s;
        int e;
        int pct;
        int el;
        int dur;
        logic [23:0] tgt;
        entry_result_t res;
        s = c.start_index;
        e = s;
        res.st = 1'b0;
        tgt = {c.blue, c.green, c.red};
        pct = (c.percent > PCT_FULL) ? int'(PCT_FULL) : int'(c.percent);
        dur = c.duration_ms;
        el = (c.elapsed_ms > c.duration_ms) ? dur : int'(c.elapsed_ms);
        if (c.action == ACT_FILL || c.action == ACT_BLEND || c.action == ACT_FADE)
        begin
            e = s + c.entry_count;
            if (e > PAL_ENTRIES)
            begin
                e = PAL_ENTRIES;
                res.st = 1'b1;
            end
        end
        case (c.action)
            ACT_WRITE: pal_model[s] = tgt;
            ACT_FILL:  for (int i = s; i < e; i++) pal_model[i] = tgt;
            ACT_BLEND: for (int i = s; i < e; i++)
                           pal_model[i] = lerp_rgb(pal_model[i], tgt, pct, int'(PCT_FULL));
            ACT_SNAP:  snap_model = pal_model;
            ACT_FADE:  for (int i = s; i < e; i++)
                           pal_model[i] = (dur == 0) ? tgt : lerp_rgb(snap_model[i], tgt, el, dur);
            default: ;
        endcase
        res.r = pal_model[s][7:0];
        res.g = pal_model[s][15:8];
        res.b = pal_model[s][23:16];
        result_queue.push_back(res);
    endtask

    function automatic palette_cmd_t mk_cmd(logic [2:0] a, int s, int n, logic [23:0] rgb,
                                            int pct, int el, int dur);
        palette_cmd_t c;
        c.action = a;
        c.start_index = s[7:0];
        c.entry_count = n[8:0];
        c.red = rgb[23:16];
        c.green = rgb[15:8];
        c.blue = rgb[7:0];
        c.percent = pct[6:0];
        c.elapsed_ms = el[15:0];
        c.duration_ms = dur[15:0];
        return c;
    endfunction

    // idle odds per phase, in percent: none, sender, receiver, both
    function automatic int phase_of();
        return (sent_cmds * 4) / (total_cmds + 1);
    endfunction

    // driver: new item at the falling edge, held until accepted
    always @(negedge clk)
    begin
        int ph;
        int idle_pct;
        palette_cmd_t c;
        ph = phase_of();
        idle_pct = (ph == 1) ? 66 : (ph == 3) ? 34 : 0;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                c = cmd_queue.pop_front();
                action <= c.action;
                start_index <= c.start_index;
                entry_count <= c.entry_count;
                red <= c.red;
                green <= c.green;
                blue <= c.blue;
                percent <= c.percent;
                elapsed_ms <= c.elapsed_ms;
                duration_ms <= c.duration_ms;
                in_valid <= 1'b1;
                sent_cmds++;
            end
            else
                in_valid <= 1'b0;
        end
        idle_pct = (ph == 2) ? 66 : (ph == 3) ? 34 : 0;
        out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // acceptance of commands and checking of result items
    always @(posedge clk)
    begin
        entry_result_t exp_r;
        if (in_valid && in_ready)
        begin
            in_taken = 1'b1;
            predict_palette(mk_cmd(action, start_index, entry_count,
                                   {red, green, blue}, percent, elapsed_ms, duration_ms));
        end
        if (out_valid && out_ready)
        begin
            if (result_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item r=%0h g=%0h b=%0h st=%0b",
                             out_red, out_green, out_blue, status);
            end
            else
            begin
                exp_r = result_queue.pop_front();
                if (out_red !== exp_r.r || out_green !== exp_r.g ||
                    out_blue !== exp_r.b || status !== exp_r.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp r=%0h g=%0h b=%0h st=%0b, ",
                                  "got r=%0h g=%0h b=%0h st=%0b"},
                                 exp_r.r, exp_r.g, exp_r.b, exp_r.st,
                                 out_red, out_green, out_blue, status);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int a;
        int n;
        int dur;
        int roll;
        // whole table written, then snapshot: no entry is ever read unwritten
        cmd_queue.push_back(mk_cmd(ACT_FILL, 0, 256, 24'h102030, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_SNAP, 0, 0, 24'h0, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_WRITE, 0, 0, 24'hffffff, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_WRITE, 255, 511, 24'h000000, 127, 65535, 65535));
        cmd_queue.push_back(mk_cmd(ACT_READ, 0, 0, 24'h0, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_READ, 255, 0, 24'hffffff, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_FILL, 250, 10, 24'ha5c35a, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_FILL, 3, 0, 24'h123456, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_BLEND, 0, 4, 24'h000000, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_BLEND, 0, 4, 24'h000000, 50, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_BLEND, 1, 3, 24'hffffff, 100, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_BLEND, 252, 511, 24'h00ff00, 127, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_SNAP, 200, 300, 24'hffffff, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(ACT_FADE, 250, 8, 24'h0000ff, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(ACT_FADE, 0, 4, 24'hff0000, 0, 65535, 100));
        cmd_queue.push_back(mk_cmd(ACT_FADE, 0, 4, 24'hff0000, 0, 0, 100));
        cmd_queue.push_back(mk_cmd(ACT_FADE, 0, 4, 24'h00ffff, 0, 32767, 65535));
        cmd_queue.push_back(mk_cmd(ACT_FADE, 4, 2, 24'h808080, 0, 65535, 65535));
        cmd_queue.push_back(mk_cmd(3'd6, 7, 5, 24'h0, 0, 0, 1));
        cmd_queue.push_back(mk_cmd(3'd7, 255, 256, 24'hffffff, 0, 0, 1));
        // random: small ranges mostly, a few long ones
        for (int k = 0; k < N_RANDOM; k++)
        begin
            roll = $urandom_range(99);
            a = (roll < 20) ? ACT_WRITE : (roll < 32) ? ACT_READ : (roll < 46) ? ACT_FILL :
                (roll < 66) ? ACT_BLEND : (roll < 74) ? ACT_SNAP : (roll < 96) ? ACT_FADE :
                $urandom_range(7, 6);
            roll = $urandom_range(99);
            n = (roll < 88) ? $urandom_range(8) : (roll < 95) ? $urandom_range(511)
                                                  : $urandom_range(256, 240);
            roll = $urandom_range(99);
            dur = (roll < 10) ? 0 : (roll < 40) ? $urandom_range(16, 1) : $urandom_range(65535, 1);
            cmd_queue.push_back(mk_cmd(a[2:0], $urandom_range(255), n, $urandom,
                                       $urandom_range(127),
                                       ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(dur),
                                       dur));
        end
        total_cmds = cmd_queue.size();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (cmd_queue.size() == 0 && !in_valid);
        wait (result_queue.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && result_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
